@@ sv/sro_pkg.sv @@
// package: payload types, register indexes, result cause codes for the overlap test
package sro_pkg;

	localparam int COORD_WIDTH = 32;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] centre_x;
		logic signed [COORD_WIDTH-1:0] centre_y;
		logic signed [COORD_WIDTH-1:0] centre_z;
		logic [COORD_WIDTH-2:0] circle_radius;
	} query_t;

	typedef struct packed {
		logic hit;
		logic [1:0] hit_cause;
	} result_t;

	typedef enum logic [2:0] {
		REG_SIDE_Y   = 3'd0,
		REG_SIDE_Z   = 3'd1,
		REG_ORIGIN_X = 3'd2,
		REG_ORIGIN_Y = 3'd3,
		REG_ORIGIN_Z = 3'd4,
		REG_ROT_ZERO = 3'd5,
		REG_ROT_ONE  = 3'd6,
		REG_ROT_TWO  = 3'd7
	} reg_idx_t;

	localparam logic [1:0] CAUSE_NONE   = 2'd0;
	localparam logic [1:0] CAUSE_INSIDE = 2'd1;
	localparam logic [1:0] CAUSE_EDGE   = 2'd2;

endpackage

@@ sv/sro_sqdist.sv @@
// squared distance pipeline: squares of three magnitudes, summed, compared to (2r)^2
module sro_sqdist #(
	parameter int MW = 36,
	parameter int RW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld,
	input  logic [MW-1:0] mx,
	input  logic [MW-1:0] my,
	input  logic [MW-1:0] mz,
	input  logic [RW-1:0] r2,
	output logic          le_vld,
	output logic          le
);
	localparam int PW = 2 * MW;
	localparam int SW = PW + 2;
	localparam int HW = (MW + 1) / 2;    // half width of a magnitude

	logic          v_s1, v_s2;
	logic [2*HW-1:0] me [3];
	logic [2*HW-1:0] mhi [3], mlo [3];
	logic [2*HW-1:0] hh_s1 [3], hl_s1 [3], ll_s1 [3];
	logic [2*RW-1:0] rr_s1, rr_s2;
	logic [SW-1:0] sum_s2;

	assign me[0] = (2*HW)'(mx);
	assign me[1] = (2*HW)'(my);
	assign me[2] = (2*HW)'(mz);

	// halves of each magnitude, zero extended
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mhi[i] = (2*HW)'(me[i][2*HW-1:HW]);
			mlo[i] = (2*HW)'(me[i][HW-1:0]);
		end
	end

	// squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= vld;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			hh_s1[i] <= mhi[i] * mhi[i];
			hl_s1[i] <= mhi[i] * mlo[i];
			ll_s1[i] <= mlo[i] * mlo[i];
		end
		rr_s1  <= (2*RW)'(r2) * (2*RW)'(r2);
		// m^2 = {hh, ll} + 2*hl shifted by the half width
		sum_s2 <= SW'({hh_s1[0], ll_s1[0]}) + SW'({hh_s1[1], ll_s1[1]}) +
		          SW'({hh_s1[2], ll_s1[2]}) +
		          (SW'(SW'(hl_s1[0]) + SW'(hl_s1[1]) + SW'(hl_s1[2])) << (HW + 1));
		rr_s2  <= rr_s1;
	end

	localparam int CW = (SW > 2 * RW) ? SW : 2 * RW;
	assign le_vld = v_s2;
	assign le     = CW'(sum_s2) <= CW'(rr_s2);

	a_le_follows: assert property (@(posedge clk) disable iff (!arst_n)
		vld |=> ##1 le_vld)
		else $error("compare valid lost");
endmodule

@@ sv/sphere_rectangle_overlap_test.sv @@
// top level: sphere versus rectangle overlap test, fully pipelined
// the result strobe is valid, registered after the s1 to s4 stages, the squarer stages and the output register
// throughput: one item per cycle; busy is always low, the receiver cannot stall
// reset: arst_n clears pipeline valid bits and loads side 1.0, origin 0, identity rotation
// the depth is set by the nine 20x33 rotation products, the adder tree and the squarer
module sphere_rectangle_overlap_test #(
	parameter int FRAC_BITS   = 16,
	parameter int ROT_WIDTH   = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  sro_pkg::query_t   query,
	output logic              valid,
	output sro_pkg::result_t  result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [5:0]        paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);
	localparam int CW   = sro_pkg::COORD_WIDTH;
	localparam int DW   = CW + 1;              // difference width
	localparam int PW   = DW + ROT_WIDTH;      // product width
	localparam int AW   = PW + 2;              // sum of three products
	localparam int SH   = ROT_WIDTH - 3;       // ROT_FRAC - 1
	localparam int LW   = AW - SH;             // local coordinate width
	localparam int MW   = LW;                  // magnitude width
	localparam int RWW  = CW + 1;              // 2r width

	// config registers
	logic [CW-2:0]          side_y_q, side_z_q;
	logic signed [CW-1:0]   org_q [3];
	logic [3*ROT_WIDTH-1:0] rot_q [3];

	logic wr_en;
	logic [2:0] ridx;
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign ridx   = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_y_q <= (CW-1)'(1) << FRAC_BITS;
			side_z_q <= (CW-1)'(1) << FRAC_BITS;
			for (int i = 0; i < 3; i++) begin
				org_q[i] <= '0;
				rot_q[i] <= (3*ROT_WIDTH)'(1) << (ROT_WIDTH * i + ROT_WIDTH - 2);
			end
		end else if (wr_en) begin
			case (ridx)
				sro_pkg::REG_SIDE_Y:   side_y_q <= pwdata[CW-2:0];
				sro_pkg::REG_SIDE_Z:   side_z_q <= pwdata[CW-2:0];
				sro_pkg::REG_ORIGIN_X: org_q[0] <= pwdata[CW-1:0];
				sro_pkg::REG_ORIGIN_Y: org_q[1] <= pwdata[CW-1:0];
				sro_pkg::REG_ORIGIN_Z: org_q[2] <= pwdata[CW-1:0];
				sro_pkg::REG_ROT_ZERO: rot_q[0] <= pwdata[3*ROT_WIDTH-1:0];
				sro_pkg::REG_ROT_ONE:  rot_q[1] <= pwdata[3*ROT_WIDTH-1:0];
				sro_pkg::REG_ROT_TWO:  rot_q[2] <= pwdata[3*ROT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			sro_pkg::REG_SIDE_Y:   prdata = 64'(side_y_q);
			sro_pkg::REG_SIDE_Z:   prdata = 64'(side_z_q);
			sro_pkg::REG_ORIGIN_X: prdata = 64'($unsigned(org_q[0]));
			sro_pkg::REG_ORIGIN_Y: prdata = 64'($unsigned(org_q[1]));
			sro_pkg::REG_ORIGIN_Z: prdata = 64'($unsigned(org_q[2]));
			sro_pkg::REG_ROT_ZERO: prdata = 64'(rot_q[0]);
			sro_pkg::REG_ROT_ONE:  prdata = 64'(rot_q[1]);
			sro_pkg::REG_ROT_TWO:  prdata = 64'(rot_q[2]);
			default:               prdata = '0;
		endcase
	end

	assign busy = 1'b0;

	// s1: centre minus origin
	logic                 v_s1;
	logic signed [DW-1:0] d_s1 [3];
	logic [CW-2:0]        rad_s1;
	// s2: nine products
	logic                 v_s2;
	logic signed [PW-1:0] p_s2 [3][3];
	logic [CW-2:0]        rad_s2;
	// s3: column sums, shifted to local coordinates
	logic                 v_s3;
	logic signed [LW-1:0] loc_s3 [3];
	logic [CW-2:0]        rad_s3;
	// s4: inside flag, magnitude of local x and clamp residual magnitudes
	logic                 v_s4;
	logic                 in_s4;
	logic [MW-1:0]        m_s4 [3];
	logic [CW-2:0]        rad_s4;
	// in_s5/in_s6 follow the squaring unit
	logic                 in_s5, in_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	logic signed [AW-1:0] acc [3];
	logic signed [LW-1:0] hy, hz, cy, cz;
	always_comb begin
		for (int i = 0; i < 3; i++)
			acc[i] = AW'(p_s2[0][i]) + AW'(p_s2[1][i]) + AW'(p_s2[2][i]);
		hy = LW'($signed({1'b0, side_y_q}));
		hz = LW'($signed({1'b0, side_z_q}));
		// residual from the clamp, zero when within the half side
		if (loc_s3[1] > hy)       cy = loc_s3[1] - hy;
		else if (loc_s3[1] < -hy) cy = loc_s3[1] + hy;
		else                      cy = '0;
		if (loc_s3[2] > hz)       cz = loc_s3[2] - hz;
		else if (loc_s3[2] < -hz) cz = loc_s3[2] + hz;
		else                      cz = '0;
	end

	always_ff @(posedge clk) begin
		d_s1[0] <= DW'(query.centre_x) - DW'(org_q[0]);
		d_s1[1] <= DW'(query.centre_y) - DW'(org_q[1]);
		d_s1[2] <= DW'(query.centre_z) - DW'(org_q[2]);
		rad_s1  <= query.circle_radius[CW-2:0];
		// p[k][i] = R[k][i] * d[k]
		for (int k = 0; k < 3; k++)
			for (int i = 0; i < 3; i++)
				p_s2[k][i] <= PW'($signed(rot_q[k][ROT_WIDTH*i +: ROT_WIDTH])) * PW'(d_s1[k]);
		rad_s2 <= rad_s1;
		for (int i = 0; i < 3; i++)
			loc_s3[i] <= LW'(acc[i] >>> SH);
		rad_s3 <= rad_s2;
		in_s4  <= (cy == '0) && (cz == '0);
		m_s4[0] <= loc_s3[0][LW-1] ? MW'(-loc_s3[0]) : MW'(loc_s3[0]);
		m_s4[1] <= cy[LW-1] ? MW'(-cy) : MW'(cy);
		m_s4[2] <= cz[LW-1] ? MW'(-cz) : MW'(cz);
		rad_s4 <= rad_s3;
		in_s5  <= in_s4;
		in_s6  <= in_s5;
	end

	logic le_vld, le;
	sro_sqdist #(.MW(MW), .RW(RWW)) u_sq (
		.clk(clk), .arst_n(arst_n), .vld(v_s4),
		.mx(m_s4[0]), .my(m_s4[1]), .mz(m_s4[2]),
		.r2({1'b0, rad_s4, 1'b0}),
		.le_vld(le_vld), .le(le)
	);

	// output register
	logic             vld_q;
	sro_pkg::result_t res_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else         vld_q <= le_vld;
	end
	always_ff @(posedge clk) begin
		res_q.hit       <= in_s6 || le;
		res_q.hit_cause <= in_s6 ? sro_pkg::CAUSE_INSIDE :
		                   (le ? sro_pkg::CAUSE_EDGE : sro_pkg::CAUSE_NONE);
	end
	assign valid  = vld_q;
	assign result = res_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> ##6 valid)
		else $error("result strobe latency broken");
	a_hit_cause: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (result.hit == (result.hit_cause != sro_pkg::CAUSE_NONE)))
		else $error("hit and cause disagree");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(v_s4, 3))
		else $error("result without item");
endmodule

@@ sim/testbench.sv @@
// testbench for the sphere versus rectangle overlap test: directed and random queries, self-checked
`timescale 1ns / 1ps

module testbench;

	localparam int LATENCY     = 7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ROT_FRAC    = 18;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	sro_pkg::query_t  query;
	logic        valid;
	sro_pkg::result_t result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	// local copy of the rectangle registers
	logic [30:0]        side_y_q, side_z_q;
	logic signed [31:0] org_x_q, org_y_q, org_z_q;
	logic [59:0]        rot_q [3];

	sro_pkg::result_t expected_hits [$];
	int      error_count;
	int      cycle_count;
	int      idle_pct;

	sphere_rectangle_overlap_test u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .query(query),
		.valid(valid), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// hard stop in case the block never answers
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// one signed q1.18 entry of a rotation row
	function automatic longint rot_entry(logic [59:0] row, int col);
		logic signed [19:0] e;
		e = row[20*col +: 20];
		return longint'(e);
	endfunction

	function automatic logic [127:0] square(longint v);
		logic signed [127:0] t;
		t = v;
		return t * t;
	endfunction

	function automatic longint clamp_sym(longint v, longint h);
		if (v > h)
			return h;
		if (v < -h)
			return -h;
		return v;
	endfunction

	// overlap decision for one query against the current rectangle
	function automatic sro_pkg::result_t overlap_of(sro_pkg::query_t q);
		longint d [3];
		longint loc [3];
		longint acc, hy, hz, cy, cz;
		logic [31:0]  r2;
		logic [127:0] sq_dist, rr;
		sro_pkg::result_t r;
		d[0] = longint'(q.centre_x) - longint'(org_x_q);
		d[1] = longint'(q.centre_y) - longint'(org_y_q);
		d[2] = longint'(q.centre_z) - longint'(org_z_q);
		// local = transpose(R) * d, kept at half an input lsb
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int k = 0; k < 3; k++)
				acc += rot_entry(rot_q[k], i) * d[k];
			loc[i] = acc >>> (ROT_FRAC - 1);
		end
		hy = longint'(side_y_q);
		hz = longint'(side_z_q);
		r.hit = 1'b0;
		r.hit_cause = sro_pkg::CAUSE_NONE;
		if (loc[1] <= hy && loc[1] >= -hy && loc[2] <= hz && loc[2] >= -hz) begin
			r.hit = 1'b1;
			r.hit_cause = sro_pkg::CAUSE_INSIDE;
		end else begin
			cy = loc[1] - clamp_sym(loc[1], hy);
			cz = loc[2] - clamp_sym(loc[2], hz);
			sq_dist = square(loc[0]) + square(cy) + square(cz);
			r2 = {q.circle_radius, 1'b0};
			rr = 128'(r2) * 128'(r2);
			if (sq_dist <= rr) begin
				r.hit = 1'b1;
				r.hit_cause = sro_pkg::CAUSE_EDGE;
			end
		end
		return r;
	endfunction

	// compare every strobed result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && valid) begin
			if (expected_hits.size() == 0) begin
				$error("unexpected result hit=%0d cause=%0d", result.hit, result.hit_cause);
				error_count++;
			end else begin
				if (result.hit !== expected_hits[0].hit) begin
					$error("hit: expected %0d, got %0d", expected_hits[0].hit, result.hit);
					error_count++;
				end
				if (result.hit_cause !== expected_hits[0].hit_cause) begin
					$error("hit_cause: expected %0d, got %0d",
						expected_hits[0].hit_cause, result.hit_cause);
					error_count++;
				end
				void'(expected_hits.pop_front());
			end
		end
	end

	// let the pipeline empty before touching registers
	task automatic drain();
		start <= 1'b0;
		while (expected_hits.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// apb write: setup then access, local copy follows the same register
	task automatic write_reg(sro_pkg::reg_idx_t idx, logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			sro_pkg::REG_SIDE_Y:   side_y_q = value[30:0];
			sro_pkg::REG_SIDE_Z:   side_z_q = value[30:0];
			sro_pkg::REG_ORIGIN_X: org_x_q = value[31:0];
			sro_pkg::REG_ORIGIN_Y: org_y_q = value[31:0];
			sro_pkg::REG_ORIGIN_Z: org_z_q = value[31:0];
			sro_pkg::REG_ROT_ZERO: rot_q[0] = value[59:0];
			sro_pkg::REG_ROT_ONE:  rot_q[1] = value[59:0];
			sro_pkg::REG_ROT_TWO:  rot_q[2] = value[59:0];
			default: ;
		endcase
	endtask

	function automatic logic [59:0] pack_row(int c0, int c1, int c2);
		logic [19:0] a, b, c;
		a = 20'(c0);
		b = 20'(c1);
		c = 20'(c2);
		return {c, b, a};
	endfunction

	task automatic write_rect(logic [30:0] sy, logic [30:0] sz, logic [31:0] ox,
			logic [31:0] oy, logic [31:0] oz, logic [59:0] r0, logic [59:0] r1,
			logic [59:0] r2);
		drain();
		write_reg(sro_pkg::REG_SIDE_Y, 64'(sy));
		write_reg(sro_pkg::REG_SIDE_Z, 64'(sz));
		write_reg(sro_pkg::REG_ORIGIN_X, 64'(ox));
		write_reg(sro_pkg::REG_ORIGIN_Y, 64'(oy));
		write_reg(sro_pkg::REG_ORIGIN_Z, 64'(oz));
		write_reg(sro_pkg::REG_ROT_ZERO, 64'(r0));
		write_reg(sro_pkg::REG_ROT_ONE, 64'(r1));
		write_reg(sro_pkg::REG_ROT_TWO, 64'(r2));
	endtask

	// present one item until it is taken, then maybe idle
	task automatic send_query(sro_pkg::query_t q);
		logic was_busy;
		int gap;
		start <= 1'b1;
		query <= q;
		do begin
			@(negedge clk);
			was_busy = busy;
			@(posedge clk);
		end while (was_busy);
		expected_hits.push_back(overlap_of(q));
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic sro_pkg::query_t mk_query(int x, int y, int z, int r);
		sro_pkg::query_t q;
		q.centre_x = x;
		q.centre_y = y;
		q.centre_z = z;
		q.circle_radius = 31'(r);
		return q;
	endfunction

	// reset values: unit square, identity frame; boundary and corner cases
	task automatic test_reset_frame();
		send_query(mk_query(0, 0, 0, 0));
		send_query(mk_query(0, 32'h8000, 32'h8000, 0));      // corner exactly on the edge
		send_query(mk_query(0, 32'h8001, 0, 0));             // just outside, zero radius
		send_query(mk_query(0, 32'h8001, 0, 1));
		send_query(mk_query(32'h10000, 0, 0, 32'h10000));    // above the face, touching
		send_query(mk_query(32'h10000, 0, 0, 32'hffff));
		send_query(mk_query(0, 32'h18000, 32'h18000, 32'hb505));
		send_query(mk_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff));
		send_query(mk_query(32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff));
		send_query(mk_query(32'h80000000, 32'h7fffffff, 32'h80000000, 0));
		send_query(mk_query(-1, -32'h8000, 32'h8000, 0));
		send_query(mk_query(32'h5555aaaa, 32'haaaa5555, 32'h0f0f0f0f, 31'h2aaaaaaa));
	endtask

	// register extremes: widest sides, far origins, extreme rotation entries
	task automatic test_register_extremes();
		write_rect(31'h7fffffff, 31'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
			pack_row(-(1 << 19), (1 << 19) - 1, 0),
			pack_row((1 << 19) - 1, -(1 << 19), -1),
			pack_row(-(1 << 19), -(1 << 19), (1 << 19) - 1));
		send_query(mk_query(32'h80000000, 32'h7fffffff, 32'h7fffffff, 0));
		send_query(mk_query(32'h7fffffff, 32'h80000000, 32'h80000000, 31'h7fffffff));
		send_query(mk_query(0, 0, 0, 0));
		send_query(mk_query(32'h7fffffff, 32'h80000000, 32'h80000000, 0));
		// smallest sides: the rectangle shrinks to a dot
		write_rect(31'd1, 31'd1, 32'h0, 32'h0, 32'h0, pack_row(0, 0, 1 << 18),
			pack_row(0, 1 << 18, 0), pack_row(1 << 18, 0, 0));
		send_query(mk_query(0, 0, 0, 0));
		send_query(mk_query(1, 0, 0, 0));
		send_query(mk_query(0, 0, 2, 1));
		send_query(mk_query(0, 3, 0, 1));
		send_query(mk_query(5, 4, 4, 3));
		// all-zero rotation collapses every centre onto the origin
		write_rect(31'h10000, 31'h20000, 32'h12345678, 32'h0, 32'hffff0000,
			60'h0, 60'h0, 60'h0);
		send_query(mk_query(32'h7fffffff, -5, 32'h1000, 0));
		send_query(mk_query(32'h80000000, 32'h80000000, 32'h80000000, 0));
	endtask

	function automatic logic [19:0] rand_entry();
		case ($urandom_range(3))
			0: return 20'h40000;
			1: return 20'hc0000;
			2: return 20'h0;
			default: return 20'($urandom);
		endcase
	endfunction

	// a random rectangle: small sides mostly, mix of clean and skewed frames
	task automatic random_rect();
		logic [30:0] sy, sz;
		logic [59:0] r [3];
		int mode;
		sy = ($urandom_range(7) == 0) ? 31'($urandom) : 31'($urandom_range(1, 1 << 20));
		sz = ($urandom_range(7) == 0) ? 31'($urandom) : 31'($urandom_range(1, 1 << 20));
		mode = $urandom_range(2);
		for (int i = 0; i < 3; i++) begin
			if (mode == 0)
				r[i] = pack_row(i == 0 ? 1 << 18 : 0, i == 1 ? 1 << 18 : 0,
					i == 2 ? 1 << 18 : 0);
			else if (mode == 1)
				r[i] = {rand_entry(), rand_entry(), rand_entry()};
			else
				r[i] = 60'({$urandom, $urandom});
		end
		write_rect(sy, sz, $urandom >>> $urandom_range(31), $urandom >>> $urandom_range(31),
			$urandom, r[0], r[1], r[2]);
	endtask

	// centres mostly around the rectangle so all three causes show up
	task automatic random_queries(int count);
		sro_pkg::query_t q;
		int sh;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(4) == 0) begin
				q.centre_x = $urandom;
				q.centre_y = $urandom;
				q.centre_z = $urandom;
				q.circle_radius = 31'($urandom);
			end else begin
				sh = $urandom_range(6, 31);
				q.centre_x = org_x_q + ($signed($urandom) >>> sh);
				q.centre_y = org_y_q + ($signed($urandom) >>> sh);
				q.centre_z = org_z_q + ($signed($urandom) >>> sh);
				q.circle_radius = 31'($urandom >> $urandom_range(1, 31));
			end
			send_query(q);
		end
	endtask

	// random rectangles under each idling pattern, including a stretch with none
	task automatic test_random_traffic();
		int pct [4] = '{0, 69, 0, 8};
		for (int p = 0; p < 4; p++) begin
			idle_pct = pct[p];
			for (int s = 0; s < 3; s++) begin
				random_rect();
				random_queries(125);
			end
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		query       = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		error_count = 0;
		cycle_count = 0;
		idle_pct    = 0;
		side_y_q    = 31'h10000;
		side_z_q    = 31'h10000;
		org_x_q     = 0;
		org_y_q     = 0;
		org_z_q     = 0;
		rot_q[0]    = 60'h40000;
		rot_q[1]    = 60'h40000 << 20;
		rot_q[2]    = 60'h40000 << 40;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_frame();
		test_register_extremes();
		test_random_traffic();

		drain();
		if (error_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
